@@ hdl/cbiq_pkg.sv @@
// Shared types and constants for the centred boxcar IQ filter.
// Holds the input and result beat structs and the configuration constants.
// Depends on nothing else in the project.
package cbiq_pkg;

  // Sample width of each I or Q component (signed Q1.15)
  localparam int SAMPLE_BITS = 16;

  // Width of the samples-per-symbol register and its reset value
  localparam int SPS_W = 7;
  localparam logic [SPS_W-1:0] SPS_RESET = 7'd8;

  // Default largest window radius
  localparam int MAX_RADIUS_DEFAULT = 9;

  // Width of the per-burst sample counter, which saturates at its top value
  localparam int COUNT_W = 16;

  // Division by 7 of a 7-bit value as (x * 147) >> 10, exact over 0..127
  localparam int RECIP_7_W = 8;
  localparam logic [RECIP_7_W-1:0] RECIP_7 = 8'd147;
  localparam int RECIP_SHIFT = 10;

  // One input beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          last_sample;
  } cbiq_in_t;

  // One result beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] avg_re;
    logic signed [SAMPLE_BITS-1:0] avg_im;
    logic                          last_output;
  } cbiq_out_t;

endpackage

@@ hdl/centered_boxcar_iq_filter_top.sv @@
// Centred boxcar (moving average) filter for complex baseband bursts.
// Uses cbiq_pkg for the beat structs and configuration constants.
//
// The filter averages each sample with its neighbours within a radius of
// max(1, samples_per_symbol / 7), clamped to MAX_RADIUS, clipping the window
// at both ends of a burst and dividing by the number of samples actually in
// it, rounded to nearest with ties away from zero. Results lag the input by
// the radius; the sample marked last flushes the remaining results, the final
// one flagged with last_output. The block works on one sample at a time and
// holds in_stall high while busy. A sample is accepted and then its work is
// planned. Each result is then accumulated from the sample store, which has
// one write port and one registered read port: a set-up step, one read per
// window sample and a drain step. Then come a rounding set-up step, the
// bit-per-cycle divider over SAMPLE_BITS (16) quotient bits and the load of
// the output register, which waits while the result register is held. A
// finished result waits in an output register, so the next sample is taken
// while it is still stalled. The sample store is not cleared at reset; no
// entry is read before the current burst has written it. cfg_ready is always
// high; write the configuration only while the block is idle.
module centered_boxcar_iq_filter_top #(
  parameter int MAX_RADIUS = cbiq_pkg::MAX_RADIUS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cbiq_pkg::cbiq_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cbiq_pkg::cbiq_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbiq_pkg::SPS_W-1:0]     cfg_samples_per_symbol
);
  import cbiq_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int MAG_W      = SAMPLE_BITS - 1 + CNT_W;
  localparam int SUM_W      = MAG_W + 1;
  localparam int QW         = SAMPLE_BITS;
  localparam int STEP_W     = $clog2(QW);
  localparam int PROD_W     = SPS_W + RECIP_7_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SETUP,
    ST_ACC,
    ST_DRAIN,
    ST_RND,
    ST_DIV,
    ST_DONE
  } state_t;

  // Radius from a samples-per-symbol value, clamped to 1..MAX_RADIUS
  function automatic logic [RAD_W-1:0] radius_of(input logic [SPS_W-1:0] sps);
    logic [PROD_W-1:0] prod;
    logic [SPS_W-1:0]  quo;
    logic [RAD_W-1:0]  rad;
    prod = PROD_W'(sps) * PROD_W'(RECIP_7);
    quo  = SPS_W'(prod >> RECIP_SHIFT);
    if (quo == '0) begin
      rad = RAD_W'(1);
    end else if (int'(quo) > MAX_RADIUS) begin
      rad = RAD_W'(MAX_RADIUS);
    end else begin
      rad = RAD_W'(quo);
    end
    return rad;
  endfunction

  state_t                    state_r;
  logic [RAD_W-1:0]          radius_r;
  logic [IDX_W-1:0]          wr_pos_r;
  logic [IDX_W-1:0]          newest_r;
  logic [COUNT_W-1:0]        taken_r;
  logic [COUNT_W-1:0]        n_r;
  logic                      last_r;
  logic [RAD_W-1:0]          d_r;
  logic [IDX_W-1:0]          t_r;
  logic [IDX_W-1:0]          t_end_r;
  logic [CNT_W-1:0]          c_r;
  logic signed [SUM_W-1:0]   acc_re_r;
  logic signed [SUM_W-1:0]   acc_im_r;
  logic                      rd_vld_r;
  logic [2*SAMPLE_BITS-1:0]  rd_word_r;
  logic                      neg_re_r;
  logic                      neg_im_r;
  logic [CNT_W-1:0]          rem_re_r;
  logic [CNT_W-1:0]          rem_im_r;
  logic [QW-1:0]             dvd_re_r;
  logic [QW-1:0]             dvd_im_r;
  logic [STEP_W-1:0]         step_r;
  logic                      out_valid_r;
  cbiq_out_t                 out_data_r;

  // Sample store: one write and one registered read per cycle
  logic [2*SAMPLE_BITS-1:0]  line_mem [LINE_DEPTH];

  logic                      in_beat;
  logic                      out_free;
  logic [IDX_W:0]            rd_addr_wide;
  logic [IDX_W-1:0]          rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_re;
  logic signed [SAMPLE_BITS-1:0] rd_im;
  logic [COUNT_W-1:0]        ahead;
  logic [RAD_W-1:0]          reach_a;
  logic [RAD_W-1:0]          flush_k;
  logic [SUM_W-1:0]          abs_re;
  logic [SUM_W-1:0]          abs_im;
  logic [MAG_W-1:0]          rnd_re;
  logic [MAG_W-1:0]          rnd_im;
  logic [CNT_W:0]            trial_re;
  logic [CNT_W:0]            trial_im;
  logic                      ge_re;
  logic                      ge_im;
  logic [QW-1:0]             q_re;
  logic [QW-1:0]             q_im;

  assign in_beat   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Ring address of the sample t_r positions behind the newest one
  assign rd_addr_wide = (newest_r >= t_r) ? {1'b0, newest_r - t_r}
                      : (IDX_W+1)'(newest_r) + (IDX_W+1)'(LINE_DEPTH) - (IDX_W+1)'(t_r);
  assign rd_addr = rd_addr_wide[IDX_W-1:0];
  assign rd_re   = rd_word_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_im   = rd_word_r[SAMPLE_BITS-1:0];

  // Window extent: samples before the centre are min(r, n - d); after it, d
  assign ahead   = n_r - COUNT_W'(d_r);
  assign reach_a = (ahead < COUNT_W'(radius_r)) ? ahead[RAD_W-1:0] : radius_r;
  assign flush_k = (n_r < COUNT_W'(radius_r)) ? n_r[RAD_W-1:0] : radius_r;

  // Magnitude plus half the divisor, for round-to-nearest
  assign abs_re = acc_re_r[SUM_W-1] ? SUM_W'(-acc_re_r) : SUM_W'(acc_re_r);
  assign abs_im = acc_im_r[SUM_W-1] ? SUM_W'(-acc_im_r) : SUM_W'(acc_im_r);
  assign rnd_re = abs_re[MAG_W-1:0] + MAG_W'(c_r >> 1);
  assign rnd_im = abs_im[MAG_W-1:0] + MAG_W'(c_r >> 1);

  // One restoring division step per cycle for each lane
  assign trial_re = {rem_re_r, dvd_re_r[QW-1]};
  assign trial_im = {rem_im_r, dvd_im_r[QW-1]};
  assign ge_re    = trial_re >= {1'b0, c_r};
  assign ge_im    = trial_im >= {1'b0, c_r};

  // Signed quotients
  assign q_re = neg_re_r ? QW'(~dvd_re_r + 1'b1) : dvd_re_r;
  assign q_im = neg_im_r ? QW'(~dvd_im_r + 1'b1) : dvd_im_r;

  // Sample store write on an input beat and registered window read
  always_ff @(posedge clk) begin
    if (in_beat) begin
      line_mem[wr_pos_r] <= {in_data.sample_re, in_data.sample_im};
    end
    rd_word_r <= line_mem[rd_addr];
  end

  // Sequencer with the shared accumulator and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= radius_of(SPS_RESET);
      wr_pos_r    <= '0;
      taken_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_ACC);

      if (cfg_valid && cfg_ready) begin
        radius_r <= radius_of(cfg_samples_per_symbol);
      end

      // Window accumulation adds each registered read word flagged by rd_vld_r
      if (rd_vld_r) begin
        acc_re_r <= acc_re_r + SUM_W'(rd_re);
        acc_im_r <= acc_im_r + SUM_W'(rd_im);
      end

      // The result register empties when its beat is taken, unless it is
      // refilled in the same cycle
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            newest_r <= wr_pos_r;
            wr_pos_r <= (wr_pos_r == IDX_W'(LINE_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
            n_r      <= taken_r;
            last_r   <= in_data.last_sample;
            if (in_data.last_sample) begin
              taken_r <= '0;
            end else if (taken_r != '1) begin
              taken_r <= taken_r + 1'b1;
            end
            state_r  <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          // An ordinary sample completes the window r behind it; the last
          // sample flushes every pending centre down to itself
          if (last_r) begin
            d_r     <= flush_k;
            state_r <= ST_SETUP;
          end else if (n_r >= COUNT_W'(radius_r)) begin
            d_r     <= radius_r;
            state_r <= ST_SETUP;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SETUP: begin
          t_r      <= '0;
          t_end_r  <= IDX_W'(d_r) + IDX_W'(reach_a);
          c_r      <= CNT_W'(d_r) + CNT_W'(reach_a) + 1'b1;
          acc_re_r <= '0;
          acc_im_r <= '0;
          state_r  <= ST_ACC;
        end
        ST_ACC: begin
          if (t_r == t_end_r) begin
            state_r <= ST_DRAIN;
          end else begin
            t_r <= t_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_RND;
        end
        ST_RND: begin
          neg_re_r <= acc_re_r[SUM_W-1];
          neg_im_r <= acc_im_r[SUM_W-1];
          rem_re_r <= CNT_W'(rnd_re >> QW);
          rem_im_r <= CNT_W'(rnd_im >> QW);
          dvd_re_r <= rnd_re[QW-1:0];
          dvd_im_r <= rnd_im[QW-1:0];
          step_r   <= '0;
          state_r  <= ST_DIV;
        end
        ST_DIV: begin
          rem_re_r <= ge_re ? CNT_W'(trial_re - {1'b0, c_r}) : CNT_W'(trial_re);
          rem_im_r <= ge_im ? CNT_W'(trial_im - {1'b0, c_r}) : CNT_W'(trial_im);
          dvd_re_r <= {dvd_re_r[QW-2:0], ge_re};
          dvd_im_r <= {dvd_im_r[QW-2:0], ge_im};
          step_r   <= step_r + 1'b1;
          if (step_r == STEP_W'(QW - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.avg_re      <= q_re;
            out_data_r.avg_im      <= q_im;
            out_data_r.last_output <= last_r && (d_r == '0);
            if (last_r && (d_r != '0)) begin
              d_r     <= d_r - 1'b1;
              state_r <= ST_SETUP;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted sample always moves the sequencer on to planning
  a_beat_to_plan: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == ST_PLAN))
    else $error("accepted sample did not start planning");

  // Read data only arrives while the window is being gathered
  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_ACC || state_r == ST_DRAIN))
    else $error("window read data outside accumulation");

  // The read offset never runs past the far end of the window
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (t_r <= t_end_r))
    else $error("window read offset past window end");

  // The divisor is never zero while dividing
  a_divisor_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (c_r != '0))
    else $error("zero divisor in divider");

  // A result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result left while output register was held");

endmodule

@@ dv/centered_boxcar_iq_filter_top_tb.sv @@
// Self-checking testbench for the centred boxcar IQ filter.
// Depends on cbiq_pkg and centered_boxcar_iq_filter_top; checks results against a
// built-in predictor of the windowed averages.
`timescale 1ns / 100ps

module centered_boxcar_iq_filter_top_tb;
  import cbiq_pkg::*;

  localparam int MAX_R          = MAX_RADIUS_DEFAULT;
  localparam int LINE_DEPTH     = 2 * MAX_R + 1;
  localparam int TARGET_SAMPLES = 470;
  localparam int SETTLE_CYCLES  = 64;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef enum logic [1:0] {STEP_SAMPLE, STEP_SPS_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    cbiq_in_t         beat;
    logic [SPS_W-1:0] sps;
    int               gap;
  } burst_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cbiq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cbiq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SPS_W-1:0] cfg_samples_per_symbol = SPS_RESET;

  // Pending stimulus and the averages still owed by the filter
  burst_step_t burst_q[$];
  cbiq_out_t avg_expected_q[$];

  // Predictor state
  logic [SPS_W-1:0] sps_model;
  logic signed [SAMPLE_BITS-1:0] ring_re [LINE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_im [LINE_DEPTH];
  int line_pos;
  logic [COUNT_W-1:0] taken_in_burst;

  // Driver, monitor and watchdog bookkeeping
  bit beat_held;
  bit sps_held;
  int gap_left;
  int stall_left;
  int rx_stall_max;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  int samples_queued;
  cbiq_out_t want_beat;

  centered_boxcar_iq_filter_top DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data                (in_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_data               (out_data),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_samples_per_symbol (cfg_samples_per_symbol)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Radius max(1, sps / 7), clamped to the largest supported radius.
  function automatic int window_radius();
    int r;
    r = int'(sps_model) / 7;
    if (r < 1) r = 1;
    if (r > MAX_R) r = MAX_R;
    return r;
  endfunction

  // Mean rounded to nearest, ties away from zero.
  function automatic logic [SAMPLE_BITS-1:0] rounded_mean(int total, int span);
    int mag;
    int q;
    mag = (total < 0) ? -total : total;
    q = (mag + span / 2) / span;
    return SAMPLE_BITS'((total < 0) ? -q : q);
  endfunction

  // Averages the window centred d samples behind the newest one, reaching
  // back_n samples further back and fwd_n samples forward.
  function automatic void push_window_average(int newest, int d, int back_n, int fwd_n,
                                               bit final_one);
    int acc_re;
    int acc_im;
    int idx;
    cbiq_out_t avg;
    acc_re = 0;
    acc_im = 0;
    for (int t = d - fwd_n; t <= d + back_n; t++) begin
      idx = (newest + LINE_DEPTH - t) % LINE_DEPTH;
      acc_re += ring_re[idx];
      acc_im += ring_im[idx];
    end
    avg.avg_re = rounded_mean(acc_re, back_n + fwd_n + 1);
    avg.avg_im = rounded_mean(acc_im, back_n + fwd_n + 1);
    avg.last_output = final_one;
    avg_expected_q.push_back(avg);
  endfunction

  // Works out the averages that one accepted sample releases.
  function automatic void predict_averages(cbiq_in_t beat);
    int newest;
    int n;
    int r;
    int k;
    int d;
    int j;
    newest = line_pos;
    n = int'(taken_in_burst);
    r = window_radius();
    ring_re[newest] = beat.sample_re;
    ring_im[newest] = beat.sample_im;
    line_pos = (newest + 1) % LINE_DEPTH;
    if (!beat.last_sample) begin
      if (n >= r) push_window_average(newest, r, lesser(r, n - r), r, 1'b0);
      if (taken_in_burst != COUNT_TOP) taken_in_burst++;
    end else begin
      // The last sample flushes every pending output with shrinking windows.
      k = lesser(n, r);
      for (j = 0; j <= k; j++) begin
        d = k - j;
        push_window_average(newest, d, lesser(r, n - d), lesser(r, d), d == 0);
      end
      taken_in_burst = '0;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_component();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SPS_W-1:0] random_sps();
    case ($urandom_range(0, 5))
      0: return 7'd4;
      1: return 7'd64;
      2: return SPS_W'($urandom_range(0, 127));
      default: return SPS_W'($urandom_range(4, 64));
    endcase
  endfunction

  function automatic void add_sample(logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im,
                                     bit final_one, int gap);
    burst_step_t s;
    s.kind = STEP_SAMPLE;
    s.beat.sample_re = re;
    s.beat.sample_im = im;
    s.beat.last_sample = final_one;
    s.sps = '0;
    s.gap = gap;
    burst_q.push_back(s);
    samples_queued++;
  endfunction

  function automatic void add_step(step_kind_t kind, logic [SPS_W-1:0] value);
    burst_step_t s;
    s.kind = kind;
    s.beat = '0;
    s.sps = value;
    s.gap = 0;
    burst_q.push_back(s);
  endfunction

  // Directed bursts first, then random bursts with register changes between
  // and occasionally inside them.
  function automatic void fill_bursts();
    int len;
    int gap_max;
    // Single-sample burst at full scale
    add_sample(16'h7FFF, 16'h8000, 1'b1, 0);
    // Rounding ties away from zero at the window edge at the start of the burst
    add_sample(16'sd1, -16'sd1, 1'b0, 0);
    add_sample(16'sd2, -16'sd2, 1'b0, 0);
    add_sample(16'sd4, -16'sd4, 1'b1, 0);
    // Constant extremes must average to themselves
    for (int i = 0; i < 3; i++) add_sample(16'h8000, 16'h7FFF, i == 2, 0);
    // Radius clamped to the maximum and a burst shorter than the radius
    add_step(STEP_SPS_WRITE, 7'd127);
    for (int i = 0; i < 4; i++) add_sample(random_component(), random_component(), i == 3, 0);
    add_step(STEP_SPS_WRITE, 7'd0);
    add_sample(16'h7FFF, 16'h7FFF, 1'b0, 3);
    add_sample(16'h7FFF, 16'h7FFF, 1'b1, 0);
    // Radius falls from the maximum to one in the middle of a burst
    add_step(STEP_SPS_WRITE, 7'd64);
    for (int i = 0; i < 10; i++) begin
      if (i == 6) add_step(STEP_SPS_WRITE, 7'd4);
      add_sample(random_component(), random_component(), i == 9, $urandom_range(0, 2));
    end
    add_step(STEP_DRAIN, '0);

    while (samples_queued < TARGET_SAMPLES) begin
      if ($urandom_range(0, 3) == 0) add_step(STEP_SPS_WRITE, random_sps());
      if ($urandom_range(0, 9) == 0) add_step(STEP_DRAIN, '0);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 49) == 0) add_step(STEP_SPS_WRITE, random_sps());
        add_sample(random_component(), random_component(), i == len - 1,
                   $urandom_range(0, gap_max));
      end
    end
  endfunction

  // Driver: presents sample beats and register writes from the queue, and
  // feeds every accepted sample to the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      sps_model = SPS_RESET;
      line_pos = 0;
      taken_in_burst = '0;
      gap_left = 0;
    end else begin
      beat_held = in_valid && in_stall;
      if (in_valid && !in_stall) predict_averages(in_data);
      sps_held = 1'b0;
      if (cfg_valid && cfg_ready) sps_model = cfg_samples_per_symbol;
      else sps_held = cfg_valid;

      if (!beat_held && !sps_held && burst_q.size() > 0) begin
        if (burst_q[0].kind == STEP_SAMPLE) begin
          if (gap_left < burst_q[0].gap) begin
            gap_left++;
          end else begin
            in_data <= burst_q[0].beat;
            beat_held = 1'b1;
            gap_left = 0;
            void'(burst_q.pop_front());
          end
        end else if (!in_valid && avg_expected_q.size() == 0 &&
                     quiet_cycles >= SETTLE_CYCLES) begin
          // The filter has gone quiet, so it is safe to change the radius.
          if (burst_q[0].kind == STEP_SPS_WRITE) begin
            cfg_samples_per_symbol <= burst_q[0].sps;
            sps_held = 1'b1;
          end
          void'(burst_q.pop_front());
        end
      end
      in_valid <= beat_held;
      cfg_valid <= sps_held;
    end
  end

  // Monitor: checks every accepted result beat and draws the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      rx_stall_max = 19;
    end else begin
      if (out_valid && !out_stall) begin
        if (avg_expected_q.size() == 0) begin
          $error("result beat with nothing expected: avg_re %0d avg_im %0d last_output %0b",
                 out_data.avg_re, out_data.avg_im, out_data.last_output);
          mismatches++;
        end else begin
          want_beat = avg_expected_q.pop_front();
          if (out_data.avg_re !== want_beat.avg_re) begin
            $error("avg_re: expected %0d, got %0d", want_beat.avg_re, out_data.avg_re);
            mismatches++;
          end
          if (out_data.avg_im !== want_beat.avg_im) begin
            $error("avg_im: expected %0d, got %0d", want_beat.avg_im, out_data.avg_im);
            mismatches++;
          end
          if (out_data.last_output !== want_beat.last_output) begin
            $error("last_output: expected %0b, got %0b", want_beat.last_output,
                   out_data.last_output);
            mismatches++;
          end
        end
        results_seen++;
        // Switch between stalling and free-running stretches now and then.
        if (results_seen % 40 == 0) rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        stall_left = $urandom_range(0, rx_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: counts cycles in which no beat of any channel is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Reset, stimulus and end of run.
  initial begin
    mismatches = 0;
    results_seen = 0;
    samples_queued = 0;
    fill_bursts();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (burst_q.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (avg_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
